/* rtl/core/sha1sh_pkg.sv */
// Package for the SHA-1 stream hasher.
// Holds the item structs, control structs, state encoding and hash constants.
// Used by sha1sh_rounds and sha1_stream_hasher.
package sha1sh_pkg;

    localparam int unsigned BLOCK_WORDS  = 16;
    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned ROUNDS       = 80;
    localparam logic [5:0]  LEN_POS      = 6'd56;
    localparam logic [7:0]  PAD_MARK     = 8'h80;

    localparam logic [DIGEST_WORDS-1:0][31:0] INIT_VALUE = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha1sh_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha1sh_out_t;

    typedef struct packed {
        logic start;
        logic restart;
    } sha1sh_ctl_t;

    typedef struct packed {
        logic round_en;
        logic expand;
        logic done;
    } sha1sh_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_HASH,
        ST_OUT
    } sha1sh_state_t;

endpackage

/* rtl/core/sha1sh_rounds.sv */
// SHA-1 compression engine: one round per cycle on a shared round unit.
// Holds the chaining value and the working variables; takes one schedule word a round.
// Depends on sha1sh_pkg.
module sha1sh_rounds (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  sha1sh_pkg::sha1sh_ctl_t                       ctl,
    input  logic [31:0]                                   sched_word,
    output sha1sh_pkg::sha1sh_stat_t                      stat,
    output logic [sha1sh_pkg::DIGEST_WORDS-1:0][31:0]     chain
);
    import sha1sh_pkg::*;

    logic [6:0]  round_reg;
    logic        busy_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [DIGEST_WORDS-1:0][31:0] cv_reg;

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic        rounds_left;

    assign rounds_left = round_reg < 7'(ROUNDS);

    always_comb
    begin
        case (round_reg) inside
            [7'd0:7'd19]:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = K0;
            end
            [7'd20:7'd39]:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K1;
            end
            [7'd40:7'd59]:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = K2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K3;
            end
        endcase
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + sched_word;
    end

    assign stat.round_en = busy_reg && rounds_left;
    assign stat.expand   = round_reg >= 7'(BLOCK_WORDS);
    assign stat.done     = busy_reg && !rounds_left;
    assign chain         = cv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= '0;
            cv_reg    <= INIT_VALUE;
        end
        else
        begin
            if (ctl.restart)
            begin
                cv_reg <= INIT_VALUE;
            end
            if (ctl.start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (stat.round_en)
            begin
                round_reg <= round_reg + 7'd1;
            end
            else if (stat.done)
            begin
                busy_reg  <= 1'b0;
                cv_reg[0] <= cv_reg[0] + a_reg;
                cv_reg[1] <= cv_reg[1] + b_reg;
                cv_reg[2] <= cv_reg[2] + c_reg;
                cv_reg[3] <= cv_reg[3] + d_reg;
                cv_reg[4] <= cv_reg[4] + e_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg <= cv_reg[0];
            b_reg <= cv_reg[1];
            c_reg <= cv_reg[2];
            d_reg <= cv_reg[3];
            e_reg <= cv_reg[4];
        end
        else if (stat.round_en)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

endmodule

/* rtl/core/sha1_stream_hasher.sv */
// SHA-1 stream hasher top level: byte collection, padding, schedule and digest output.
// Depends on sha1sh_pkg and sha1sh_rounds.
//
// Message bytes are taken one per cycle while the block is idle. The 64th byte of a
// block hands the block to one shared round unit that runs one SHA-1 round per cycle.
// A block pass is a start, the 80 rounds and a chaining update. The start is made in
// the cycle that accepts the 64th byte, and no item is accepted until the pass ends.
// The end of a message adds a padding step that starts one more block pass. It adds
// two such passes when the message leaves 56 or more bytes in its last block. Then
// the digest words H0 to H4 are delivered, each held while the output stalls, after
// which the hasher starts a fresh message.
module sha1_stream_hasher (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     msg_valid,
    output logic                     msg_stall,
    input  sha1sh_pkg::sha1sh_in_t   msg,
    output logic                     digest_valid,
    input  logic                     digest_stall,
    output sha1sh_pkg::sha1sh_out_t  digest
);
    import sha1sh_pkg::*;

    sha1sh_state_t state_reg, state_next;
    logic [5:0]    fill_reg, fill_next;
    logic [63:0]   len_reg, len_next;
    logic          eom_reg, eom_next;
    logic          mark_reg, mark_next;
    logic          lastblk_reg, lastblk_next;
    logic [2:0]    idx_reg, idx_next;
    logic [BLOCK_WORDS-1:0][31:0] win_reg, win_next;

    sha1sh_ctl_t   ctl;
    sha1sh_stat_t  stat;
    logic [DIGEST_WORDS-1:0][31:0] chain;
    logic [31:0]   sched_word;
    logic [31:0]   mix;
    logic          len_here;
    logic [5:0]    pos;

    sha1sh_rounds u_rounds (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sched_word (sched_word),
        .stat       (stat),
        .chain      (chain)
    );

    assign mix        = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign sched_word = stat.expand ? {mix[30:0], mix[31]} : win_reg[0];
    assign len_here   = mark_reg || (fill_reg < LEN_POS);

    assign msg_stall          = state_reg != ST_IDLE;
    assign digest_valid       = state_reg == ST_OUT;
    assign digest.digest_word = chain[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = idx_reg == 3'(DIGEST_WORDS - 1);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        eom_next     = eom_reg;
        mark_next    = mark_reg;
        lastblk_next = lastblk_reg;
        idx_next     = idx_reg;
        win_next     = win_reg;
        ctl          = '0;
        pos          = '0;

        if (stat.round_en)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[BLOCK_WORDS-1] = sched_word;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    eom_next = msg.end_of_message;
                    if (msg.byte_present)
                    begin
                        win_next[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] = msg.data_byte;
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + 64'd8;
                    end
                    if (msg.byte_present && fill_reg == 6'd63)
                    begin
                        ctl.start    = 1'b1;
                        lastblk_next = 1'b0;
                        state_next   = ST_HASH;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                for (int j = 0; j < BLOCK_WORDS; j++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        pos = 6'(4 * j + b);
                        if (pos >= fill_reg)
                        begin
                            if (!mark_reg && pos == fill_reg)
                            begin
                                win_next[j][8*(3-b) +: 8] = PAD_MARK;
                            end
                            else
                            begin
                                win_next[j][8*(3-b) +: 8] = 8'h00;
                            end
                        end
                    end
                end
                if (len_here)
                begin
                    win_next[BLOCK_WORDS-2] = len_reg[63:32];
                    win_next[BLOCK_WORDS-1] = len_reg[31:0];
                end
                lastblk_next = len_here;
                mark_next    = 1'b1;
                fill_next    = '0;
                ctl.start    = 1'b1;
                state_next   = ST_HASH;
            end
            ST_HASH:
            begin
                if (stat.done)
                begin
                    if (lastblk_reg)
                    begin
                        idx_next   = '0;
                        state_next = ST_OUT;
                    end
                    else if (eom_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (!digest_stall)
                begin
                    if (idx_reg == 3'(DIGEST_WORDS - 1))
                    begin
                        ctl.restart  = 1'b1;
                        fill_next    = '0;
                        len_next     = '0;
                        eom_next     = 1'b0;
                        mark_next    = 1'b0;
                        lastblk_next = 1'b0;
                        idx_next     = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            len_reg     <= '0;
            eom_reg     <= 1'b0;
            mark_reg    <= 1'b0;
            lastblk_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            eom_reg     <= eom_next;
            mark_reg    <= mark_next;
            lastblk_reg <= lastblk_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

/* bench/tb.sv */
// Self-checking testbench for sha1_stream_hasher: streams byte messages and compares
// every digest word against a SHA-1 computation kept inside the bench.
// Depends on sha1sh_pkg and the sha1_stream_hasher RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1sh_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TARGET_ITEMS   = 410;
    localparam int SETTLE_CYCLES  = 200;
    localparam int BYTES_PER_BLK  = 64;
    localparam int LENGTH_AT      = 56;
    localparam int HASH_WORDS     = 5;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;
    localparam logic [31:0] RK0 = 32'h5a827999;
    localparam logic [31:0] RK1 = 32'h6ed9eba1;
    localparam logic [31:0] RK2 = 32'h8f1bbcdc;
    localparam logic [31:0] RK3 = 32'hca62c1d6;

    logic        clk;
    logic        rst_n;
    logic        msg_valid;
    logic        msg_stall;
    sha1sh_in_t  msg;
    logic        digest_valid;
    logic        digest_stall;
    sha1sh_out_t digest;

    logic [31:0] chain_value [HASH_WORDS];
    logic [7:0]  block_bytes [BYTES_PER_BLK];
    int          block_fill;
    logic [63:0] message_bits;
    sha1sh_out_t pending_digest [$];

    int error_count;
    int hashed_items;
    int burst_left;
    int quiet_cycles;

    sha1_stream_hasher uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void restart_hash();
        int i;
        chain_value[0] = IV0;
        chain_value[1] = IV1;
        chain_value[2] = IV2;
        chain_value[3] = IV3;
        chain_value[4] = IV4;
        for (i = 0; i < BYTES_PER_BLK; i++)
            block_bytes[i] = 8'h00;
        block_fill = 0;
        message_bits = 64'd0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
        a = chain_value[0];
        b = chain_value[1];
        c = chain_value[2];
        d = chain_value[3];
        e = chain_value[4];
        for (r = 0; r < 80; r++)
        begin
            if (r >= 16)
                w[r % 16] = rol32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16]
                                  ^ w[r % 16], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = RK0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = RK1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RK2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RK3;
            end
            t = rol32(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_value[0] += a;
        chain_value[1] += b;
        chain_value[2] += c;
        chain_value[3] += d;
        chain_value[4] += e;
    endfunction

    // Absorbs one accepted item and queues the five digest words when the message ends.
    function automatic void sha1_absorb(input sha1sh_in_t it);
        int pos;
        int i;
        sha1sh_out_t word;
        if (it.byte_present)
        begin
            block_bytes[block_fill] = it.data_byte;
            block_fill++;
            message_bits += 64'd8;
            if (block_fill == BYTES_PER_BLK)
            begin
                compress_block();
                block_fill = 0;
            end
        end
        if (!it.end_of_message)
            return;
        pos = block_fill;
        block_bytes[pos] = PAD_BYTE;
        pos++;
        if (pos > LENGTH_AT)
        begin
            while (pos < BYTES_PER_BLK)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < LENGTH_AT)
        begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        for (i = 0; i < 8; i++)
            block_bytes[LENGTH_AT + i] = message_bits[63 - 8*i -: 8];
        compress_block();
        for (i = 0; i < HASH_WORDS; i++)
        begin
            word.digest_word = chain_value[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == HASH_WORDS - 1);
            pending_digest.push_back(word);
        end
        restart_hash();
    endfunction

    function automatic sha1sh_in_t make_item(input logic [7:0] data, input logic present,
                                             input logic last);
        sha1sh_in_t it;
        it.data_byte      = data;
        it.byte_present   = present;
        it.end_of_message = last;
        return it;
    endfunction

    task automatic send_item(input sha1sh_in_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                msg_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        msg_valid <= 1'b1;
        msg <= it;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        sha1_absorb(it);
        hashed_items++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && digest_valid && !digest_stall)
        begin
            if (pending_digest.size() == 0)
            begin
                $error("unexpected digest item: word %0h index %0d last %0b",
                       digest.digest_word, digest.word_index, digest.last_word);
                error_count++;
            end
            else
            begin
                sha1sh_out_t want;
                want = pending_digest.pop_front();
                if (digest.digest_word !== want.digest_word)
                begin
                    $error("digest_word: expected %08h, actual %08h",
                           want.digest_word, digest.digest_word);
                    error_count++;
                end
                if (digest.word_index !== want.word_index)
                begin
                    $error("word_index: expected %0d, actual %0d",
                           want.word_index, digest.word_index);
                    error_count++;
                end
                if (digest.last_word !== want.last_word)
                begin
                    $error("last_word: expected %0b, actual %0b",
                           want.last_word, digest.last_word);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((msg_valid && !msg_stall) || (digest_valid && !digest_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL sha1_stream_hasher");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int span;
        digest_stall <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: digest_stall <= 1'b0;
                    1: digest_stall <= ($urandom_range(0, 1) == 1);
                    2: digest_stall <= ($urandom_range(0, 3) != 0);
                    default: digest_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic test_empty_message();
        send_item(make_item(8'($urandom), 1'b0, 1'b1));
    endtask

    task automatic test_ignored_items();
        send_item(make_item(8'hff, 1'b0, 1'b0));
        send_item(make_item(8'h00, 1'b0, 1'b0));
        send_item(make_item(8'hff, 1'b0, 1'b1));
    endtask

    task automatic test_abc();
        send_item(make_item(8'h61, 1'b1, 1'b0));
        send_item(make_item(8'h62, 1'b1, 1'b0));
        send_item(make_item(8'h63, 1'b0, 1'b0));
        send_item(make_item(8'h63, 1'b1, 1'b1));
    endtask

    task automatic test_byte_extremes();
        send_item(make_item(8'h00, 1'b1, 1'b0));
        send_item(make_item(8'hff, 1'b1, 1'b0));
        send_item(make_item(8'h80, 1'b1, 1'b0));
        send_item(make_item(8'h55, 1'b0, 1'b1));
        send_item(make_item(8'hff, 1'b1, 1'b1));
        send_item(make_item(8'h00, 1'b1, 1'b1));
    endtask

    // Lengths cluster on the padding boundaries: 55 and 56 bytes in the last block,
    // and messages that end exactly on a full block.
    task automatic test_random_messages();
        int kind;
        int len;
        int i;
        logic end_with_byte;
        while (hashed_items < TARGET_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                len = $urandom_range(0, 8);
            else if (kind < 7)
                len = 55 + 64 * $urandom_range(0, 1) + $urandom_range(0, 9);
            else
                len = $urandom_range(0, 140);
            end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_item(make_item(8'($urandom), 1'b0, 1'b0));
                send_item(make_item(8'($urandom), 1'b1, end_with_byte && (i == len - 1)));
            end
            if (!end_with_byte)
                send_item(make_item(8'($urandom), 1'b0, 1'b1));
        end
    endtask

    initial
    begin
        error_count = 0;
        hashed_items = 0;
        burst_left = 0;
        quiet_cycles = 0;
        restart_hash();
        rst_n <= 1'b0;
        msg_valid <= 1'b0;
        msg <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_ignored_items();
        test_abc();
        test_byte_extremes();
        test_random_messages();

        msg_valid <= 1'b0;
        while (pending_digest.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_digest.size() == 0)
            $display("PASS sha1_stream_hasher");
        else
            $display("FAIL sha1_stream_hasher");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sha1sh_pkg.sv
rtl/core/sha1sh_rounds.sv
rtl/core/sha1_stream_hasher.sv
bench/tb.sv
